FILE: rtl/fpba_pkg.sv
package fpba_pkg;

  // fixed widths of the channel fields and registers
  localparam int CMD_W        = 1;
  localparam int BLK_IDX_W    = 5;
  localparam int SIZE_FIELD_W = 16;
  localparam int MODE_W       = 2;
  localparam int COUNT_W      = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = 1;
  localparam int QUEUE_CNT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } fpba_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  fit_mode;
    logic [COUNT_W-1:0] block_count;
  } fpba_cfg_t;

  typedef struct packed {
    logic scanning;
    logic res_load;
  } fpba_stat_t;

endpackage

FILE: rtl/fpba_if.sv
interface fpba_in_if;
  logic                              valid;
  logic                              ready;
  logic [fpba_pkg::CMD_W-1:0]        cmd;
  logic [fpba_pkg::BLK_IDX_W-1:0]    block_index;
  logic [fpba_pkg::SIZE_FIELD_W-1:0] size_value;

  modport source (output valid, output cmd, output block_index, output size_value,
                  input ready);
  modport sink (input valid, input cmd, input block_index, input size_value,
                output ready);
endinterface

interface fpba_out_if;
  logic                              valid;
  logic                              ready;
  logic                              granted;
  logic [fpba_pkg::BLK_IDX_W-1:0]    chosen_block;
  logic [fpba_pkg::SIZE_FIELD_W-1:0] space_left;

  modport source (output valid, output granted, output chosen_block, output space_left,
                  input ready);
  modport sink (input valid, input granted, input chosen_block, input space_left,
                output ready);
endinterface

FILE: rtl/fpba_front.sv
module fpba_front #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fpba_in_if.sink              in_chan,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic                 q_is_req,
  output logic [IDX_W-1:0]     q_idx,
  output logic [SIZE_BITS-1:0] q_size
);

  logic                               q_req_r  [fpba_pkg::QUEUE_DEPTH];
  logic [IDX_W-1:0]                   q_idx_r  [fpba_pkg::QUEUE_DEPTH];
  logic [SIZE_BITS-1:0]               q_size_r [fpba_pkg::QUEUE_DEPTH];
  logic [fpba_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [fpba_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [fpba_pkg::QUEUE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                               accept;
  logic                               is_req;
  logic                               push;
  logic                               pop;

  assign in_chan.ready = (cnt_r != fpba_pkg::QUEUE_CNT_W'(fpba_pkg::QUEUE_DEPTH));
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_req        = (in_chan.cmd == fpba_pkg::CMD_REQUEST);
  // loads aimed past the table are dropped here
  assign push          = accept && (is_req || (32'(in_chan.block_index) < NUM_BLOCKS));

  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_is_req = q_req_r[rd_ptr_r];
  assign q_idx    = q_idx_r[rd_ptr_r];
  assign q_size   = q_size_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_req_r[wr_ptr_r]  <= is_req;
      q_idx_r[wr_ptr_r]  <= IDX_W'(in_chan.block_index);
      q_size_r[wr_ptr_r] <= SIZE_BITS'(in_chan.size_value);
    end
  end

endmodule

FILE: rtl/fpba_back.sv
module fpba_back #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 5,
  parameter int CNT_W      = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpba_pkg::fpba_cfg_t  cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic                 q_is_req,
  input  logic [IDX_W-1:0]     q_idx,
  input  logic [SIZE_BITS-1:0] q_size,
  fpba_out_if.source           out_chan,
  output fpba_pkg::fpba_stat_t stat
);

  logic [SIZE_BITS-1:0]  block_remaining_r [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]  rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [SIZE_BITS-1:0]  mem_wdata;

  fpba_pkg::fpba_state_t state_r, state_nxt;
  logic [SIZE_BITS-1:0]  req_size_r, req_size_nxt;
  logic [CNT_W-1:0]      limit_r, limit_nxt;
  logic [CNT_W-1:0]      limit_in;
  logic [CNT_W-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic                  eval_valid_r, eval_valid_nxt;
  logic [IDX_W-1:0]      eval_idx_r, eval_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      chosen_r, chosen_nxt;
  logic [SIZE_BITS-1:0]  best_val_r, best_val_nxt;
  logic                  fits;
  logic                  better;
  logic                  slot_free;
  logic                  issue;

  logic                  out_valid_r, out_valid_nxt;
  logic                  res_load;
  logic                  res_granted;
  logic [IDX_W-1:0]      res_idx;
  logic [SIZE_BITS-1:0]  res_space;
  logic                  out_granted_r;
  logic [fpba_pkg::BLK_IDX_W-1:0]    out_block_r;
  logic [fpba_pkg::SIZE_FIELD_W-1:0] out_space_r;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign issue     = (state_r == fpba_pkg::ST_SCAN) && (scan_cnt_r < limit_r);
  assign rd_addr   = issue ? scan_cnt_r[IDX_W-1:0] : '0;

  // blocks in use, clipped to the table size
  assign limit_in = (32'(cfg.block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                         : CNT_W'(cfg.block_count);

  assign fits   = (rd_data_r >= req_size_r);
  assign better = (cfg.fit_mode == fpba_pkg::FIT_BEST)  ? (rd_data_r < best_val_r) :
                  (cfg.fit_mode == fpba_pkg::FIT_WORST) ? (rd_data_r > best_val_r) : 1'b0;

  always_comb begin
    state_nxt      = state_r;
    req_size_nxt   = req_size_r;
    limit_nxt      = limit_r;
    scan_cnt_nxt   = scan_cnt_r;
    eval_valid_nxt = 1'b0;
    eval_idx_nxt   = eval_idx_r;
    found_nxt      = found_r;
    chosen_nxt     = chosen_r;
    best_val_nxt   = best_val_r;
    q_ready        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = q_idx;
    mem_wdata      = q_size;
    res_load       = 1'b0;
    res_granted    = 1'b0;
    res_idx        = '0;
    res_space      = '0;

    // candidate check runs on the registered table read, in the cycle after its address is issued
    if (eval_valid_r && fits && (!found_r || better)) begin
      found_nxt    = 1'b1;
      chosen_nxt   = eval_idx_r;
      best_val_nxt = rd_data_r;
    end

    unique case (state_r)
      fpba_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (!q_is_req) begin
            q_ready = 1'b1;
            mem_we  = 1'b1;
          end else if (limit_in == '0) begin
            if (slot_free) begin
              q_ready  = 1'b1;
              res_load = 1'b1;
            end
          end else begin
            q_ready      = 1'b1;
            req_size_nxt = q_size;
            limit_nxt    = limit_in;
            scan_cnt_nxt = '0;
            found_nxt    = 1'b0;
            state_nxt    = fpba_pkg::ST_SCAN;
          end
        end
      end
      fpba_pkg::ST_SCAN: begin
        if (issue) begin
          eval_valid_nxt = 1'b1;
          eval_idx_nxt   = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt   = scan_cnt_r + 1'b1;
        end else if (!eval_valid_r) begin
          state_nxt = fpba_pkg::ST_DONE;
        end
      end
      fpba_pkg::ST_DONE: begin
        if (slot_free) begin
          res_load    = 1'b1;
          res_granted = found_r;
          if (found_r) begin
            mem_we    = 1'b1;
            mem_waddr = chosen_r;
            mem_wdata = best_val_r - req_size_r;
            res_idx   = chosen_r;
            res_space = best_val_r - req_size_r;
          end
          state_nxt = fpba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fpba_pkg::ST_IDLE;
      eval_valid_r <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      eval_valid_r <= eval_valid_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_size_r <= req_size_nxt;
    limit_r    <= limit_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    eval_idx_r <= eval_idx_nxt;
    chosen_r   <= chosen_nxt;
    best_val_r <= best_val_nxt;
    if (res_load) begin
      out_granted_r <= res_granted;
      out_block_r   <= fpba_pkg::BLK_IDX_W'(res_idx);
      out_space_r   <= fpba_pkg::SIZE_FIELD_W'(res_space);
    end
  end

  // table with one write port and one registered read port: one write, one read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_remaining_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= block_remaining_r[rd_addr];
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.granted      = out_granted_r;
  assign out_chan.chosen_block = out_block_r;
  assign out_chan.space_left   = out_space_r;

  assign stat.scanning = (state_r == fpba_pkg::ST_SCAN);
  assign stat.res_load = res_load;

endmodule

FILE: rtl/fit_policy_block_allocator_top.sv
// First, best or worst fit block allocator. A load request (cmd 0) writes the
// free size of one table block and returns nothing; an allocation request
// (cmd 1) searches blocks 0 to min(block_count, NUM_BLOCKS)-1, takes the
// first, smallest or largest block that still holds the requested size
// (lowest index on ties), subtracts the size and returns the block and its
// space left, or granted 0. A two-entry queue sits between the input side and
// the table engine, and a result register holds the answer, so requests are
// still taken while a result waits. The table has one write port and one
// registered read port, read one entry a cycle. A load is written at once;
// an allocation scans, then writes back when the result register is free.
// Blocks must be loaded before a request searches them; fit_mode and
// block_count must be written only while the block is idle (not enforced).
module fit_policy_block_allocator_top #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  fpba_in_if.sink                             in_chan,
  fpba_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  fpba_pkg::fpba_cfg_t  cfg_r;
  fpba_pkg::fpba_stat_t stat;
  logic                 q_valid;
  logic                 q_ready;
  logic                 q_is_req;
  logic [IDX_W-1:0]     q_idx;
  logic [SIZE_BITS-1:0] q_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpba_pkg::CFG_FIT_MODE:    cfg_r.fit_mode    <= cfg_wdata[fpba_pkg::MODE_W-1:0];
        fpba_pkg::CFG_BLOCK_COUNT: cfg_r.block_count <= cfg_wdata[fpba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  fpba_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_is_req (q_is_req),
    .q_idx    (q_idx),
    .q_size   (q_size)
  );

  fpba_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_is_req (q_is_req),
    .q_idx    (q_idx),
    .q_size   (q_size),
    .out_chan (out_chan),
    .stat     (stat)
  );

`ifndef SYNTHESIS
  // a new result never overwrites one that has not been taken
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten while stalled");

  // a refusal carries zero block and zero space
  a_refusal_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.granted) |->
      (out_chan.chosen_block == '0 && out_chan.space_left == '0))
    else $error("refused request with non-zero fields");

  // input side only stalls when the queue holds work
  a_stall_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_valid)
    else $error("input stalled with empty queue");

  // results are only loaded outside the table walk
  a_no_result_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scanning |-> !stat.res_load)
    else $error("result loaded during scan");
`endif

endmodule

FILE: bench/tb_fit_policy_block_allocator_top.sv
module tb_fit_policy_block_allocator_top;

  localparam int NUM_BLOCKS    = 32;
  localparam int SIZE_BITS     = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 44;

  typedef struct packed {
    logic                              granted;
    logic [fpba_pkg::BLK_IDX_W-1:0]    chosen_block;
    logic [fpba_pkg::SIZE_FIELD_W-1:0] space_left;
  } grant_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  fpba_in_if  in_chan ();
  fpba_out_if out_chan ();

  fit_policy_block_allocator_top #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the allocator table and its registers
  logic [fpba_pkg::SIZE_FIELD_W-1:0] free_space [NUM_BLOCKS];
  logic [fpba_pkg::MODE_W-1:0]       model_mode = fpba_pkg::FIT_FIRST;
  logic [fpba_pkg::COUNT_W-1:0]      model_count = '0;
  grant_t                            pending_grants [$];

  int unsigned n_errors = 0;
  int unsigned n_loads = 0;
  int unsigned n_requests = 0;
  int unsigned n_grants = 0;
  int unsigned n_refusals = 0;
  int unsigned reqs_by_mode [4] = '{0, 0, 0, 0};

  bit          gaps_on = 1'b0;
  int unsigned burst_left = 0;
  int unsigned ready_run = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic grant_t allocate_request(logic [fpba_pkg::SIZE_FIELD_W-1:0] req);
    int     limit;
    int     pick;
    bit     found;
    grant_t res;
    limit = (model_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(model_count);
    found = 1'b0;
    pick  = 0;
    for (int i = 0; i < limit; i++) begin
      if (free_space[i] >= req) begin
        if (!found) begin
          found = 1'b1;
          pick  = i;
          // first fit, and the unused mode, stop at the first block that fits
          if (model_mode != fpba_pkg::FIT_BEST && model_mode != fpba_pkg::FIT_WORST) break;
        end else if (model_mode == fpba_pkg::FIT_BEST && free_space[i] < free_space[pick]) begin
          pick = i;
        end else if (model_mode == fpba_pkg::FIT_WORST &&
                     free_space[i] > free_space[pick]) begin
          pick = i;
        end
      end
    end
    res = '0;
    if (found) begin
      free_space[pick]  = free_space[pick] - req;
      res.granted       = 1'b1;
      res.chosen_block  = fpba_pkg::BLK_IDX_W'(pick);
      res.space_left    = free_space[pick];
    end
    return res;
  endfunction

  // tracks register writes and requests, and checks every result
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == fpba_pkg::CFG_FIT_MODE) begin
          model_mode = cfg_wdata[fpba_pkg::MODE_W-1:0];
        end else if (cfg_index == fpba_pkg::CFG_BLOCK_COUNT) begin
          model_count = cfg_wdata[fpba_pkg::COUNT_W-1:0];
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_grants.size() == 0) begin
          $error("result with no request outstanding: granted %0d block %0d space %0d",
                 out_chan.granted, out_chan.chosen_block, out_chan.space_left);
          n_errors++;
        end else begin
          want = pending_grants.pop_front();
          if (out_chan.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_chan.granted);
            n_errors++;
          end
          if (out_chan.chosen_block !== want.chosen_block) begin
            $error("chosen_block: expected %0d, got %0d", want.chosen_block,
                   out_chan.chosen_block);
            n_errors++;
          end
          if (out_chan.space_left !== want.space_left) begin
            $error("space_left: expected %0d, got %0d", want.space_left,
                   out_chan.space_left);
            n_errors++;
          end
          if (want.granted) n_grants++;
          else n_refusals++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.cmd == fpba_pkg::CMD_LOAD) begin
          free_space[in_chan.block_index] = in_chan.size_value;
          n_loads++;
        end else begin
          pending_grants.push_back(allocate_request(in_chan.size_value));
          reqs_by_mode[model_mode]++;
          n_requests++;
        end
      end
    end
  end

  // result side back-pressure: long open stretches, short and long stalls, jitter
  always @(negedge clk) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_chan.ready <= 1'b1;
          ready_run = $urandom_range(10, 60);
        end
        1: begin
          out_chan.ready <= 1'b0;
          ready_run = $urandom_range(1, 3);
        end
        2: begin
          out_chan.ready <= 1'b0;
          ready_run = $urandom_range(5, 25);
        end
        default: begin
          out_chan.ready <= 1'($urandom_range(0, 1));
          ready_run = 1;
        end
      endcase
    end else begin
      ready_run--;
    end
  end

  // called and left at a falling edge
  task automatic send_item(logic [fpba_pkg::CMD_W-1:0] cmd,
                           logic [fpba_pkg::BLK_IDX_W-1:0] idx,
                           logic [fpba_pkg::SIZE_FIELD_W-1:0] size);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= cmd;
    in_chan.block_index <= idx;
    in_chan.size_value  <= size;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic request(logic [fpba_pkg::SIZE_FIELD_W-1:0] size);
    send_item(fpba_pkg::CMD_REQUEST,
              fpba_pkg::BLK_IDX_W'($urandom_range(0, NUM_BLOCKS - 1)), size);
  endtask

  // loads carry no result, so allow the engine to finish any still queued
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [fpba_pkg::CFG_IDX_W-1:0] idx,
                           logic [fpba_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [fpba_pkg::SIZE_FIELD_W-1:0] pick_request_size();
    int b;
    b = $urandom_range(0, NUM_BLOCKS - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return free_space[b];
      4:       return free_space[b] + 1'b1;
      5, 6:    return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 255));
      default: return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [fpba_pkg::SIZE_FIELD_W-1:0] pick_load_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 1000));
      default: return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // registers at reset value: no block in use, so nothing is granted
  task automatic test_empty_table();
    gaps_on = 1'b0;
    request('0);
    request('1);
    wait_idle();
  endtask

  task automatic test_fit_rules();
    gaps_on = 1'b0;
    write_reg(fpba_pkg::CFG_BLOCK_COUNT, 6'd4);
    send_item(fpba_pkg::CMD_LOAD, 5'd0, 16'd40);
    send_item(fpba_pkg::CMD_LOAD, 5'd1, 16'd200);
    send_item(fpba_pkg::CMD_LOAD, 5'd2, 16'd40);
    send_item(fpba_pkg::CMD_LOAD, 5'd3, 16'hFFFF);
    request(16'd30);
    request('0);
    wait_idle();
    write_reg(fpba_pkg::CFG_FIT_MODE, fpba_pkg::FIT_BEST);
    request(16'd40);
    // blocks 0 and 1 tie at 200, lowest index wins
    send_item(fpba_pkg::CMD_LOAD, 5'd0, 16'd200);
    request(16'd150);
    wait_idle();
    write_reg(fpba_pkg::CFG_FIT_MODE, fpba_pkg::FIT_WORST);
    request(16'hFFFF);
    request(16'd100);
    request('0);
    wait_idle();
    write_reg(fpba_pkg::CFG_FIT_MODE, fpba_pkg::MODE_W'(3));
    request(16'd1);
    request(16'hFFFF);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [fpba_pkg::COUNT_W-1:0] count_plan [12] = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd2,
                                                      6'd33, 6'd5, 6'd16, 6'd31, 6'd32,
                                                      6'd40, 6'd20};
    gaps_on    = 1'b1;
    burst_left = 0;
    // every block is loaded before any search can reach it
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      send_item(fpba_pkg::CMD_LOAD, fpba_pkg::BLK_IDX_W'(b), pick_load_size());
    end
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      write_reg(fpba_pkg::CFG_FIT_MODE, fpba_pkg::MODE_W'(p % 4));
      write_reg(fpba_pkg::CFG_BLOCK_COUNT, count_plan[p]);
      gaps_on    = (p % 3 != 1);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 30)
          send_item(fpba_pkg::CMD_LOAD,
                    fpba_pkg::BLK_IDX_W'($urandom_range(0, NUM_BLOCKS - 1)),
                    pick_load_size());
        else
          request(pick_request_size());
      end
    end
    wait_idle();
  endtask

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.cmd         = fpba_pkg::CMD_LOAD;
    in_chan.block_index = '0;
    in_chan.size_value  = '0;
    out_chan.ready      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fit_rules();
    test_random_traffic();
    $display("covered %0d loads and %0d allocation requests, %0d granted, %0d refused",
             n_loads, n_requests, n_grants, n_refusals);
    $display("requests by mode first/best/worst/unused: %0d/%0d/%0d/%0d",
             reqs_by_mode[0], reqs_by_mode[1], reqs_by_mode[2], reqs_by_mode[3]);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timed out with %0d results outstanding", pending_grants.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: fit_policy_block_allocator_top.f
rtl/fpba_pkg.sv
rtl/fpba_if.sv
rtl/fpba_front.sv
rtl/fpba_back.sv
rtl/fit_policy_block_allocator_top.sv
bench/tb_fit_policy_block_allocator_top.sv
